// ===== rtl/core/assert_macros.svh =====
// ------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define LFD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after antecedent
`define LFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lfd_pkg.sv =====
// ------------------------------------------------------------------------
// lfd_pkg
// types, register indexes and crc helper for the link frame deframer
// ------------------------------------------------------------------------
package lfd_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIGN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_REQ    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_REPEAT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_ACK     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_INVALID = 3'd6;

  localparam logic [7:0] CRC_INIT = 8'hff;

  localparam logic [8:0] POS_TYPE   = 9'd1;
  localparam logic [8:0] POS_SOURCE = 9'd2;
  localparam logic [8:0] POS_TARGET = 9'd3;
  localparam logic [8:0] POS_TX     = 9'd4;
  localparam logic [8:0] POS_RX     = 9'd5;
  localparam logic [8:0] POS_HCRC   = 9'd6;
  localparam logic [8:0] POS_LEN    = 9'd7;
  localparam logic [8:0] POS_DATA   = 9'd8;

  typedef struct packed {
    logic [7:0] frame_sign;
    logic [7:0] crc_poly;
    logic [7:0] start_req;
    logic [7:0] start_ans;
    logic [7:0] code_repeat;
    logic [7:0] code_ack;
    logic [7:0] code_invalid;
  } cfg_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] frame_type;
    logic [7:0] source_id;
    logic [7:0] target_id;
    logic [7:0] tx_count;
    logic [7:0] rx_count;
    logic [7:0] payload_len;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       payload_ok;
  } res_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ poly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/link_frame_deframer.sv =====
// crc update and parsing are combinational; results are then registered
// throughput: one byte per cycle while no result waits in the skid entry
// a two-entry output buffer lets a byte be taken while one result waits
// reset: synchronous active low; restores register defaults, hunts for sign
// ------------------------------------------------------------------------
// link_frame_deframer
// receive-side deframer: sign hunt, header parse, header and payload crc
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module link_frame_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_result_kind,
  output logic [7:0]                    out_frame_type,
  output logic [7:0]                    out_source_id,
  output logic [7:0]                    out_target_id,
  output logic [7:0]                    out_tx_count,
  output logic [7:0]                    out_rx_count,
  output logic [7:0]                    out_payload_len,
  output logic [7:0]                    out_payload_byte,
  output logic [7:0]                    out_payload_index,
  output logic                          out_payload_ok,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import lfd_pkg::*;

  cfg_t cfg_r;
  res_t res;
  res_t main_r, skid_r;
  logic main_valid_r, skid_valid_r;
  logic step, res_valid, pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign step      = in_valid && in_ready;
  assign pop       = main_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_sign   <= 8'd173;
      cfg_r.crc_poly     <= 8'd7;
      cfg_r.start_req    <= 8'd0;
      cfg_r.start_ans    <= 8'd1;
      cfg_r.code_repeat  <= 8'd3;
      cfg_r.code_ack     <= 8'd4;
      cfg_r.code_invalid <= 8'd255;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_SIGN:   cfg_r.frame_sign   <= cfg_data;
        REG_CRC_POLY:     cfg_r.crc_poly     <= cfg_data;
        REG_START_REQ:    cfg_r.start_req    <= cfg_data;
        REG_START_ANS:    cfg_r.start_ans    <= cfg_data;
        REG_CODE_REPEAT:  cfg_r.code_repeat  <= cfg_data;
        REG_CODE_ACK:     cfg_r.code_ack     <= cfg_data;
        REG_CODE_INVALID: cfg_r.code_invalid <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step      (step),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!main_valid_r || pop) begin
      main_valid_r <= res_valid;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (!main_valid_r || pop) begin
      if (res_valid) begin
        main_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid         = main_valid_r;
  assign out_result_kind   = main_r.result_kind;
  assign out_frame_type    = main_r.frame_type;
  assign out_source_id     = main_r.source_id;
  assign out_target_id     = main_r.target_id;
  assign out_tx_count      = main_r.tx_count;
  assign out_rx_count      = main_r.rx_count;
  assign out_payload_len   = main_r.payload_len;
  assign out_payload_byte  = main_r.payload_byte;
  assign out_payload_index = main_r.payload_index;
  assign out_payload_ok    = main_r.payload_ok;

  `LFD_ASSERT(a_skid_behind_main, !skid_valid_r || main_valid_r, "skid full with main empty")
  `LFD_ASSERT_NEXT(a_skid_holds, skid_valid_r && !out_ready, skid_valid_r, "skid word lost")
  `LFD_ASSERT_NEXT(a_stall_fills_skid, res_valid && main_valid_r && !out_ready, skid_valid_r, "result dropped on stall")
  `LFD_ASSERT(a_byte_not_ok, !out_valid || out_result_kind || !out_payload_ok, "payload word flagged ok")

endmodule

// ===== rtl/core/lfd_parser.sv =====
// ------------------------------------------------------------------------
// lfd_parser
// frame header and payload parser with header and payload crc checks
// ------------------------------------------------------------------------
module lfd_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  lfd_pkg::cfg_t cfg,
  input  logic          step,
  input  logic [7:0]    rx_byte,
  output logic          res_valid,
  output lfd_pkg::res_t res
);
  import lfd_pkg::*;

  logic       in_frame_r, in_frame_nxt;
  logic [8:0] pos_r, pos_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] type_r, type_nxt;
  logic [7:0] src_r, src_nxt;
  logic [7:0] tgt_r, tgt_nxt;
  logic [7:0] txc_r, txc_nxt;
  logic [7:0] rxc_r, rxc_nxt;
  logic [7:0] len_r, len_nxt;

  logic [7:0] crc_upd, crc_fresh;
  logic       is_start;
  logic       emit;
  logic       kind;
  logic [7:0] out_type;
  logic [7:0] pbyte;
  logic [7:0] pidx;
  logic       ok;
  logic [8:0] end_pos;

  assign crc_upd   = crc8_step(crc_r, rx_byte, cfg.crc_poly);
  assign crc_fresh = crc8_step(CRC_INIT, rx_byte, cfg.crc_poly);
  assign is_start  = (type_r == cfg.start_req) || (type_r == cfg.start_ans);
  assign end_pos   = {1'b0, len_r} + POS_DATA;

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    type_nxt     = type_r;
    src_nxt      = src_r;
    tgt_nxt      = tgt_r;
    txc_nxt      = txc_r;
    rxc_nxt      = rxc_r;
    len_nxt      = len_r;
    emit         = 1'b0;
    kind         = 1'b1;
    out_type     = type_r;
    pbyte        = 8'd0;
    pidx         = 8'd0;
    ok           = 1'b1;
    if (!in_frame_r) begin
      if (rx_byte == cfg.frame_sign) begin
        in_frame_nxt = 1'b1;
        pos_nxt      = POS_TYPE;
        crc_nxt      = crc_fresh;
        type_nxt     = cfg.code_invalid;
        txc_nxt      = 8'd0;
        rxc_nxt      = 8'd0;
        len_nxt      = 8'd0;
      end
    end else if (pos_r == POS_TYPE) begin
      crc_nxt  = crc_upd;
      type_nxt = rx_byte;
      if (rx_byte == cfg.code_invalid) begin
        in_frame_nxt = 1'b0;
      end else begin
        pos_nxt = POS_SOURCE;
      end
    end else if (pos_r <= POS_TARGET) begin
      crc_nxt = crc_upd;
      if (pos_r == POS_SOURCE) begin
        src_nxt = rx_byte;
      end else begin
        tgt_nxt = rx_byte;
      end
      pos_nxt = pos_r + 9'd1;
    end else if (is_start) begin
      in_frame_nxt = 1'b0;
      emit         = (crc_r == rx_byte);
    end else if (pos_r == POS_TX) begin
      txc_nxt = rx_byte;
      crc_nxt = crc_upd;
      pos_nxt = POS_RX;
    end else if (type_r == cfg.code_repeat) begin
      in_frame_nxt = 1'b0;
      emit         = (crc_r == rx_byte);
    end else if (pos_r == POS_RX) begin
      rxc_nxt = rx_byte;
      crc_nxt = crc_upd;
      pos_nxt = POS_HCRC;
    end else if (pos_r == POS_HCRC) begin
      if (crc_r != rx_byte) begin
        in_frame_nxt = 1'b0;
      end else if (type_r == cfg.code_ack) begin
        in_frame_nxt = 1'b0;
        emit         = 1'b1;
      end else begin
        pos_nxt = POS_LEN;
      end
    end else if (pos_r == POS_LEN) begin
      len_nxt = rx_byte;
      if (rx_byte == 8'd0) begin
        in_frame_nxt = 1'b0;
        emit         = 1'b1;
        out_type     = cfg.code_ack;
      end else begin
        crc_nxt = crc_fresh;
        pos_nxt = POS_DATA;
      end
    end else if (pos_r >= end_pos) begin
      in_frame_nxt = 1'b0;
      emit         = 1'b1;
      ok           = (crc_r == rx_byte);
      out_type     = ok ? type_r : cfg.code_ack;
    end else begin
      crc_nxt  = crc_upd;
      pos_nxt  = pos_r + 9'd1;
      emit     = 1'b1;
      kind     = 1'b0;
      ok       = 1'b0;
      pbyte    = rx_byte;
      pidx     = pos_r[7:0] - POS_DATA[7:0];
    end
  end

  assign res_valid         = step && emit;
  assign res.result_kind   = kind;
  assign res.frame_type    = out_type;
  assign res.source_id     = src_nxt;
  assign res.target_id     = tgt_nxt;
  assign res.tx_count      = txc_nxt;
  assign res.rx_count      = rxc_nxt;
  assign res.payload_len   = len_nxt;
  assign res.payload_byte  = pbyte;
  assign res.payload_index = pidx;
  assign res.payload_ok    = ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= 9'd0;
      crc_r      <= 8'd0;
      type_r     <= 8'd0;
      src_r      <= 8'd0;
      tgt_r      <= 8'd0;
      txc_r      <= 8'd0;
      rxc_r      <= 8'd0;
      len_r      <= 8'd0;
    end else if (step) begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      type_r     <= type_nxt;
      src_r      <= src_nxt;
      tgt_r      <= tgt_nxt;
      txc_r      <= txc_nxt;
      rxc_r      <= rxc_nxt;
      len_r      <= len_nxt;
    end
  end

endmodule
